>>> src/dacc_pkg.sv
// Shared types, codes and the coin table for the decimal amount coin change block.
// Used by dacc_front, dacc_back and decimal_amount_coin_change; has no dependencies of its own.
package dacc_pkg;

    localparam int AMOUNT_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH         = 4;
    localparam int DIV_STEP            = 16;
    localparam int COIN_KINDS          = 9;
    localparam int COUNT_W             = 24;

    // Division of a 25-bit partial value by 500 as (v >> 2) * DIV500_MAGIC >> DIV500_SHIFT.
    localparam int                      DIV500_MAGIC_W = 24;
    localparam logic [DIV500_MAGIC_W-1:0] DIV500_MAGIC = 24'd8589935;
    localparam int                      DIV500_SHIFT   = 30;
    localparam logic [8:0]              BIG_COIN       = 9'd500;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_END    = 1'b1;

    localparam logic [1:0] KIND_COIN  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] FRAC_MAX = 2'd2;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         coin_index;
        logic [COUNT_W-1:0] coin_count;
        logic               last;
    } t_out;

    function automatic logic [8:0] coin_value(input logic [3:0] idx);
        logic [8:0] v;
        unique case (idx)
            4'd0:    v = 9'd500;
            4'd1:    v = 9'd200;
            4'd2:    v = 9'd100;
            4'd3:    v = 9'd50;
            4'd4:    v = 9'd20;
            4'd5:    v = 9'd10;
            4'd6:    v = 9'd5;
            4'd7:    v = 9'd2;
            4'd8:    v = 9'd1;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/dacc_front.sv
// Front end: parses the character stream into a grosze value and an error flag.
// Pushes one job per end request into the job queue; uses dacc_pkg.
module dacc_front #(
    parameter int AMOUNT_BITS = dacc_pkg::AMOUNT_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  dacc_pkg::t_in        i_data,
    output logic                 o_stall,
    input  logic                 i_full,
    output logic                 o_push,
    output logic [AMOUNT_BITS:0] o_job
);

    logic [AMOUNT_BITS-1:0] r_acc, n_acc;
    logic                   r_sep, n_sep;
    logic [1:0]             r_frac, n_frac;
    logic                   r_err, n_err;

    logic                   accept;
    logic                   is_sep;
    logic                   is_digit;
    logic [AMOUNT_BITS+3:0] ext;
    logic [AMOUNT_BITS+3:0] mul;
    logic                   mul_ovf;
    logic [AMOUNT_BITS+6:0] e7;
    logic [AMOUNT_BITS+6:0] scaled;
    logic                   scale_ovf;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign is_sep   = (i_data.char_code == dacc_pkg::CH_DOT) ||
                      (i_data.char_code == dacc_pkg::CH_COMMA);
    assign is_digit = (i_data.char_code >= dacc_pkg::CH_ZERO) &&
                      (i_data.char_code <= dacc_pkg::CH_NINE);

    assign ext     = {4'b0000, r_acc};
    assign mul     = (ext << 3) + (ext << 1) + (AMOUNT_BITS + 4)'(i_data.char_code[3:0]);
    assign mul_ovf = |mul[AMOUNT_BITS+3:AMOUNT_BITS];

    assign e7 = {7'b0000000, r_acc};

    always_comb begin
        unique case (r_frac)
            2'd0:    scaled = (e7 << 6) + (e7 << 5) + (e7 << 2);
            2'd1:    scaled = (e7 << 3) + (e7 << 1);
            default: scaled = e7;
        endcase
    end

    assign scale_ovf = |scaled[AMOUNT_BITS+6:AMOUNT_BITS];

    assign o_push = accept && (i_data.func == dacc_pkg::FUNC_END);
    assign o_job  = {r_err || scale_ovf, scaled[AMOUNT_BITS-1:0]};

    always_comb begin
        n_acc  = r_acc;
        n_sep  = r_sep;
        n_frac = r_frac;
        n_err  = r_err;
        if (accept) begin
            if (i_data.func == dacc_pkg::FUNC_END) begin
                n_acc  = '0;
                n_sep  = 1'b0;
                n_frac = 2'd0;
                n_err  = 1'b0;
            end else if (!r_err) begin
                if (is_sep) begin
                    if (r_sep) begin
                        n_err = 1'b1;
                    end else begin
                        n_sep = 1'b1;
                    end
                end else if (is_digit) begin
                    if (r_sep && (r_frac == dacc_pkg::FRAC_MAX)) begin
                        n_err = 1'b1;
                    end else if (mul_ovf) begin
                        n_err = 1'b1;
                    end else begin
                        n_acc = mul[AMOUNT_BITS-1:0];
                        if (r_sep) begin
                            n_frac = r_frac + 2'd1;
                        end
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_sep  <= 1'b0;
            r_frac <= 2'd0;
            r_err  <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_sep  <= n_sep;
            r_frac <= n_frac;
            r_err  <= n_err;
        end
    end

endmodule

>>> src/dacc_queue.sv
// Short job queue between the parser and the change engine.
// Register array with head read; uses no package items.
module dacc_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> src/dacc_back.sv
// Change engine: divides each job by 500 sixteen bits per cycle by reciprocal
// multiplication, walks the smaller coins and drives the registered result channel; uses dacc_pkg.
module dacc_back #(
    parameter int AMOUNT_BITS = dacc_pkg::AMOUNT_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  logic [AMOUNT_BITS:0] i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    output dacc_pkg::t_out       o_data,
    input  logic                 i_stall
);

    localparam int STEP    = dacc_pkg::DIV_STEP;
    localparam int DIV_CYC = (AMOUNT_BITS + STEP - 1) / STEP;
    localparam int NUM_W   = DIV_CYC * STEP;
    localparam int STEPS_W = $clog2(DIV_CYC + 1);
    localparam int CW      = dacc_pkg::COUNT_W;
    localparam int V_W     = STEP + 9;
    localparam int N_W     = V_W - 2;
    localparam int P_W     = N_W + dacc_pkg::DIV500_MAGIC_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [8:0]         r_rem, n_rem;
    logic [CW-1:0]      r_quo, n_quo;
    logic               r_quo_nz, n_quo_nz;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic [3:0]         r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    dacc_pkg::t_out     r_out, n_out;

    logic               out_free;
    logic               job_bad;
    logic [V_W-1:0]     div_v;
    logic [N_W-1:0]     div_n;
    logic [P_W-1:0]     div_prod;
    logic [V_W-1:0]     div_back;
    logic [V_W-1:0]     div_left;
    logic [STEP-1:0]    qb;
    logic [8:0]         coin;
    logic [9:0]         coin2;
    logic [1:0]         cnt_small;
    logic [9:0]         sub;
    logic [8:0]         new_rem;
    logic               emit_any;
    dacc_pkg::t_out     emit_item;

    assign out_free = !r_out_valid || !i_stall;
    assign job_bad  = i_job[AMOUNT_BITS];
    assign o_pop    = (r_state == ST_IDLE) && !i_empty && (!job_bad || out_free);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign div_v    = {r_rem, r_num[NUM_W-1 -: STEP]};
    assign div_n    = div_v[V_W-1:2];
    assign div_prod = P_W'(div_n) * P_W'(dacc_pkg::DIV500_MAGIC);
    assign qb       = div_prod[dacc_pkg::DIV500_SHIFT +: STEP];
    assign div_back = V_W'(qb) * V_W'(dacc_pkg::BIG_COIN);
    assign div_left = div_v - div_back;

    assign coin  = dacc_pkg::coin_value(r_idx);
    assign coin2 = {coin, 1'b0};

    always_comb begin
        if ({1'b0, r_rem} >= coin2) begin
            cnt_small = 2'd2;
            sub       = coin2;
        end else if (r_rem >= coin) begin
            cnt_small = 2'd1;
            sub       = {1'b0, coin};
        end else begin
            cnt_small = 2'd0;
            sub       = '0;
        end
    end

    always_comb begin
        emit_item = '0;
        if (r_idx == 4'd0) begin
            new_rem  = r_rem;
            emit_any = 1'b1;
            if (!r_quo_nz && (r_rem == '0)) begin
                emit_item.kind = dacc_pkg::KIND_DONE;
                emit_item.last = 1'b1;
            end else if (r_quo_nz) begin
                emit_item.kind       = dacc_pkg::KIND_COIN;
                emit_item.coin_index = r_idx;
                emit_item.coin_count = r_quo;
                emit_item.last       = (r_rem == '0);
            end else begin
                emit_any = 1'b0;
            end
        end else begin
            new_rem              = r_rem - sub[8:0];
            emit_any             = (cnt_small != 2'd0);
            emit_item.kind       = dacc_pkg::KIND_COIN;
            emit_item.coin_index = r_idx;
            emit_item.coin_count = CW'(cnt_small);
            emit_item.last       = (new_rem == '0);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_quo_nz    = r_quo_nz;
        n_steps     = r_steps;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    if (job_bad) begin
                        n_out_valid     = 1'b1;
                        n_out           = '0;
                        n_out.kind      = dacc_pkg::KIND_ERROR;
                        n_out.last      = 1'b1;
                    end else begin
                        n_num    = NUM_W'(i_job[AMOUNT_BITS-1:0]);
                        n_rem    = '0;
                        n_quo    = '0;
                        n_quo_nz = 1'b0;
                        n_steps  = STEPS_W'(DIV_CYC);
                        n_state  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_num    = r_num << STEP;
                n_rem    = div_left[8:0];
                n_quo    = {r_quo[CW-STEP-1:0], qb};
                n_quo_nz = r_quo_nz || (|qb);
                n_steps  = r_steps - STEPS_W'(1);
                if (r_steps == STEPS_W'(1)) begin
                    n_idx   = 4'd0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (emit_any) begin
                        n_out_valid = 1'b1;
                        n_out       = emit_item;
                    end
                    n_rem = new_rem;
                    n_idx = r_idx + 4'd1;
                    if (new_rem == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_steps     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_steps     <= n_steps;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_quo_nz <= n_quo_nz;
        r_out    <= n_out;
    end

endmodule

>>> src/decimal_amount_coin_change.sv
// Decimal amount to coin change: one character request per cycle, stalled only while the
// four-entry job queue is full. The change engine pops a job only while idle, so a new job waits
// until the last one is done. It divides the job by 500 sixteen bits a cycle, then walks one coin
// a cycle while the result channel is not stalled, registering each coin result; an error job
// registers its error result when it is popped.
// Synchronous active-low reset clears the parser, the queue and the result register.
module decimal_amount_coin_change #(
    parameter int AMOUNT_BITS = dacc_pkg::AMOUNT_BITS_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  dacc_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output dacc_pkg::t_out o_out_data,
    input  logic           i_out_stall
);

    localparam int JOB_W = AMOUNT_BITS + 1;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [JOB_W-1:0] q_wdata;
    logic [JOB_W-1:0] q_rdata;

    dacc_front #(
        .AMOUNT_BITS(AMOUNT_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in_valid),
        .i_data (i_in_data),
        .o_stall(o_in_stall),
        .i_full (q_full),
        .o_push (q_push),
        .o_job  (q_wdata)
    );

    dacc_queue #(
        .WIDTH(JOB_W),
        .DEPTH(dacc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .i_pop  (q_pop),
        .o_data (q_rdata),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    dacc_back #(
        .AMOUNT_BITS(AMOUNT_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(q_empty),
        .i_job  (q_rdata),
        .o_pop  (q_pop),
        .o_valid(o_out_valid),
        .o_data (o_out_data),
        .i_stall(i_out_stall)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from an empty queue");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind != dacc_pkg::KIND_COIN)) |-> o_out_data.last)
        else $error("error or done result without last");

    a_coin_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == dacc_pkg::KIND_COIN))
            |-> (o_out_data.coin_index < 4'(dacc_pkg::COIN_KINDS)))
        else $error("coin index out of range");
`endif

endmodule

>>> verif/decimal_amount_coin_change_test.sv
`timescale 1ns / 100ps
// Self-checking bench for decimal_amount_coin_change: sends ASCII amount requests and
// compares every coin line with an in-bench greedy change predictor. Depends on dacc_pkg.
module decimal_amount_coin_change_test;

    localparam int AMT_BITS = dacc_pkg::AMOUNT_BITS_DEFAULT;
    localparam logic [63:0] AMOUNT_LIMIT = {64{1'b1}} >> (64 - AMT_BITS);
    localparam int RANDOM_ITEMS = 246;
    localparam int HOLD_AT = 60;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT = 1000;
    localparam int TABLE_ROWS = 24;

    localparam logic [63:0] GROSZE_PER_COIN [0:dacc_pkg::COIN_KINDS-1] = '{
        64'd500, 64'd200, 64'd100, 64'd50, 64'd20, 64'd10, 64'd5, 64'd2, 64'd1
    };

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic       typed;
        logic [1:0] kind;
    } t_amount_row;

    // The end rows with typed set expect exactly one result of the given kind.
    localparam t_amount_row AMOUNT_TABLE [0:TABLE_ROWS-1] = '{
        {dacc_pkg::FUNC_END,    8'h00,                    1'b1, dacc_pkg::KIND_DONE},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_DOT,         1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_END,    8'hFF,                    1'b1, dacc_pkg::KIND_DONE},
        {dacc_pkg::FUNC_APPEND, 8'h00,                    1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_ZERO + 8'd5, 1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_END,    8'h00,                    1'b1, dacc_pkg::KIND_ERROR},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_COMMA,       1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_DOT,         1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_END,    8'h55,                    1'b1, dacc_pkg::KIND_ERROR},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_ZERO + 8'd7, 1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_DOT,         1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_ZERO + 8'd2, 1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_ZERO + 8'd9, 1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_ZERO + 8'd1, 1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_END,    8'hAA,                    1'b1, dacc_pkg::KIND_ERROR},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_ZERO,        1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_COMMA,       1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_ZERO + 8'd2, 1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_ZERO + 8'd9, 1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_END,    8'h00,                    1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_APPEND, 8'hFF,                    1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_END,    8'hFF,                    1'b1, dacc_pkg::KIND_ERROR},
        {dacc_pkg::FUNC_APPEND, dacc_pkg::CH_ZERO,        1'b0, dacc_pkg::KIND_COIN},
        {dacc_pkg::FUNC_END,    8'h0F,                    1'b1, dacc_pkg::KIND_DONE}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    dacc_pkg::t_in in_data = '0;
    logic out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    dacc_pkg::t_out o_out_data;

    t_amount_row amount_rows_q[$];
    dacc_pkg::t_out change_expected_q[$];
    dacc_pkg::t_out change_step_q[$];

    logic [63:0] acc_grosze = '0;
    logic sep_seen = 1'b0;
    logic [1:0] frac_digits = '0;
    logic amount_bad = 1'b0;

    int mismatches = 0;
    int accepted_n = 0;
    int idle_cycles = 0;
    logic holding = 1'b0;
    logic hold_done = 1'b0;

    decimal_amount_coin_change #(
        .AMOUNT_BITS(AMT_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(out_stall)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // Returns the overflow flag above v * 10 + add.
    function automatic logic [64:0] times_ten_plus(logic [63:0] v, logic [63:0] add);
        if (v > (AMOUNT_LIMIT - add) / 64'd10) begin
            return {1'b1, v};
        end
        return {1'b0, v * 64'd10 + add};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Greedy change predictor; fills change_step_q with the results of one request.
    task automatic predict_change(input dacc_pkg::t_in req);
        logic [64:0] r;
        logic [63:0] grosze;
        logic [63:0] cnt;
        logic bad;
        logic have_line;
        dacc_pkg::t_out line;
        int s;
        int i;
        change_step_q.delete();
        if (req.func == dacc_pkg::FUNC_APPEND) begin
            if (!amount_bad) begin
                if (req.char_code == dacc_pkg::CH_DOT || req.char_code == dacc_pkg::CH_COMMA) begin
                    if (sep_seen) begin
                        amount_bad = 1'b1;
                    end else begin
                        sep_seen = 1'b1;
                    end
                end else if (req.char_code >= dacc_pkg::CH_ZERO &&
                             req.char_code <= dacc_pkg::CH_NINE) begin
                    r = times_ten_plus(acc_grosze, {56'd0, req.char_code - dacc_pkg::CH_ZERO});
                    if (sep_seen && frac_digits >= dacc_pkg::FRAC_MAX) begin
                        amount_bad = 1'b1;
                    end else if (r[64]) begin
                        amount_bad = 1'b1;
                    end else begin
                        acc_grosze = r[63:0];
                        if (sep_seen) begin
                            frac_digits = frac_digits + 2'd1;
                        end
                    end
                end else begin
                    amount_bad = 1'b1;
                end
            end
            return;
        end
        grosze = acc_grosze;
        bad = amount_bad;
        for (s = int'(frac_digits); s < int'(dacc_pkg::FRAC_MAX) && !bad; s++) begin
            r = times_ten_plus(grosze, 64'd0);
            if (r[64]) begin
                bad = 1'b1;
            end else begin
                grosze = r[63:0];
            end
        end
        line = '0;
        have_line = 1'b0;
        if (bad) begin
            line.kind = dacc_pkg::KIND_ERROR;
            have_line = 1'b1;
        end else begin
            for (i = 0; i < dacc_pkg::COIN_KINDS; i++) begin
                cnt = grosze / GROSZE_PER_COIN[i];
                if (cnt != 0) begin
                    if (have_line) begin
                        change_step_q.push_back(line);
                    end
                    line.kind = dacc_pkg::KIND_COIN;
                    line.coin_index = i[3:0];
                    line.coin_count = cnt[dacc_pkg::COUNT_W-1:0];
                    grosze = grosze - cnt * GROSZE_PER_COIN[i];
                    have_line = 1'b1;
                end
            end
            if (!have_line) begin
                line.kind = dacc_pkg::KIND_DONE;
            end
        end
        line.last = 1'b1;
        change_step_q.push_back(line);
        acc_grosze = '0;
        sep_seen = 1'b0;
        frac_digits = '0;
        amount_bad = 1'b0;
    endtask

    task automatic queue_random_amount();
        logic [7:0] text[$];
        logic [7:0] c;
        string lit;
        int shape;
        int n_int;
        int n_frac;
        int k;
        t_amount_row row;
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
            case ($urandom_range(0, 3))
                0: lit = "42949672.95";
                1: lit = "42949672.96";
                2: lit = "4294967295";
                default: lit = "42949672,9";
            endcase
            for (k = 0; k < lit.len(); k++) begin
                text.push_back(lit[k]);
            end
        end else begin
            n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 5);
            for (k = 0; k < n_int; k++) begin
                c = dacc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
                text.push_back(c);
            end
            if ($urandom_range(0, 9) < 6) begin
                text.push_back($urandom_range(0, 1) ? dacc_pkg::CH_DOT : dacc_pkg::CH_COMMA);
                n_frac = $urandom_range(0, 2);
                for (k = 0; k < n_frac; k++) begin
                    c = dacc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
                    text.push_back(c);
                end
            end
            if (shape >= 82) begin
                case ($urandom_range(0, 2))
                    0: begin
                        c = 8'($urandom_range(0, 255));
                        text.insert($urandom_range(0, text.size()), c);
                    end
                    1: begin
                        c = $urandom_range(0, 1) ? dacc_pkg::CH_DOT : dacc_pkg::CH_COMMA;
                        text.insert($urandom_range(0, text.size()), c);
                    end
                    default: begin
                        text.push_back(dacc_pkg::CH_DOT);
                        for (k = 0; k < 3; k++) begin
                            c = dacc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
                            text.push_back(c);
                        end
                    end
                endcase
            end
        end
        row = '0;
        row.func = dacc_pkg::FUNC_APPEND;
        foreach (text[j]) begin
            row.char_code = text[j];
            amount_rows_q.push_back(row);
        end
        row.func = dacc_pkg::FUNC_END;
        row.char_code = 8'($urandom_range(0, 255));
        amount_rows_q.push_back(row);
    endtask

    initial begin : stimulus
        t_amount_row row;
        dacc_pkg::t_in req;
        dacc_pkg::t_out want;
        int gap;
        for (int i = 0; i < TABLE_ROWS; i++) begin
            amount_rows_q.push_back(AMOUNT_TABLE[i]);
        end
        while (amount_rows_q.size() < TABLE_ROWS + RANDOM_ITEMS) begin
            queue_random_amount();
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (amount_rows_q[n]) begin
            row = amount_rows_q[n];
            req.func = row.func;
            req.char_code = row.char_code;
            gap = holding ? 0 : pick_gap();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= req;
            @(posedge clk);
            while (o_in_stall) begin
                @(posedge clk);
            end
            accepted_n++;
            predict_change(req);
            if (row.typed) begin
                want = '0;
                want.kind = row.kind;
                want.last = 1'b1;
                change_expected_q.push_back(want);
            end else begin
                foreach (change_step_q[k]) begin
                    change_expected_q.push_back(change_step_q[k]);
                end
            end
        end
        in_valid <= 1'b0;
        while (change_expected_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : drain_control
        int n;
        int m;
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            if (!hold_done && accepted_n >= HOLD_AT) begin
                holding = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
                hold_done = 1'b1;
            end
            n = pick_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            repeat (m) @(posedge clk);
        end
    end

    always @(posedge clk) begin : result_check
        dacc_pkg::t_out want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (change_expected_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_out_data), 64'd0);
            end else begin
                want = change_expected_q.pop_front();
                if (o_out_data.kind != want.kind) begin
                    report_mismatch("kind", 64'(o_out_data.kind), 64'(want.kind));
                end
                if (o_out_data.coin_index != want.coin_index) begin
                    report_mismatch("coin_index", 64'(o_out_data.coin_index),
                                    64'(want.coin_index));
                end
                if (o_out_data.coin_count != want.coin_count) begin
                    report_mismatch("coin_count", 64'(o_out_data.coin_count),
                                    64'(want.coin_count));
                end
                if (o_out_data.last != want.last) begin
                    report_mismatch("last", 64'(o_out_data.last), 64'(want.last));
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
